### sv/serpgg_pkg.sv
// ----------------------------------------------------------------------------
// serpgg_pkg
// Shared constants and the quarter-wave sine polynomial for the serpenoid
// gait generator.
// ----------------------------------------------------------------------------
package serpgg_pkg;

    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 40;

    // register indexes on the configuration channel
    localparam logic [CFG_INDEX_W-1:0] CFG_PHASE_PER_SEGMENT = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_PHASE_PER_TIME    = 8'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_EVEN_LEAD         = 8'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_AMP_EVEN_FRONT    = 8'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_AMP_EVEN_BACK     = 8'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_AMP_ODD_FRONT     = 8'd5;
    localparam logic [CFG_INDEX_W-1:0] CFG_AMP_ODD_BACK      = 8'd6;
    localparam logic [CFG_INDEX_W-1:0] CFG_OFFSET_WORDS      = 8'd7;

    localparam int SEG_W  = 7;
    localparam int GOAL_W = 10;

    localparam logic signed [12:0] GOAL_CENTER = 13'sd511;
    localparam logic signed [12:0] GOAL_MAX    = 13'sd1023;

    localparam longint SIN_A = 51472;
    localparam longint SIN_B = 21024;
    localparam longint SIN_C = 2320;

    // Q1.15 sine for table entry k of a table with 2^bits entries;
    // evaluated at elaboration only.
    function automatic logic signed [15:0] sine_entry(input int k, input int bits);
        longint qsize;
        longint quad;
        longint r;
        longint z;
        longint zz;
        longint z2;
        longint t;
        longint u;
        longint y;
        qsize = longint'(1) << (bits - 2);
        quad  = (longint'(k) >> (bits - 2)) & 3;
        r     = longint'(k) & (qsize - 1);
        z     = quad[0] ? (qsize - r) : r;
        zz    = z << (17 - bits);
        z2    = (zz * zz) >> 15;
        t     = SIN_B - ((z2 * SIN_C) >> 15);
        u     = SIN_A - ((z2 * t) >> 15);
        y     = (zz * u) >> 15;
        if (y > 32767) begin
            y = 32767;
        end
        if (quad[1]) begin
            y = -y;
        end
        return 16'(y);
    endfunction

endpackage

### sv/serpenoid_gait_generator_core.sv
// ----------------------------------------------------------------------------
// serpenoid_gait_generator_core
// Turns one gait time stamp into one servo goal per snake segment.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one item per time stamp (tdata = time_stamp, Q8.8).
//   m_ channel: SEGMENTS items per time stamp, segments 1..SEGMENTS in order,
//               tlast on the final segment.
//   cfg channel: register index + data, always ready; write only when idle.
// Timing:
//   A sequencer issues one segment per cycle when not stalled, into a
//   four-register pipeline (issue, sine lookup, multiply-add, round/saturate).
//   Each time stamp holds the sequencer until its final segment issues, and
//   the next one is taken in the cycle the final segment issues, so while
//   m_tready stays high the output runs at one goal per cycle.
// Stall:
//   When m_tready is low with a goal held, the whole pipeline and the
//   sequencer freeze; nothing is dropped or repeated. s_tready falls while
//   the sequencer is busy.
// Reset:
//   aresetn (synchronous, active low) empties the pipeline and loads the
//   register defaults.
// ----------------------------------------------------------------------------
module serpenoid_gait_generator_core #(
    parameter int SEGMENTS        = 16,
    parameter int SINE_TABLE_BITS = 10
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // s_tdata: [15:0] time_stamp
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [15:0]                         s_tdata,
    // m_tdata: [6:0] segment, [16:7] servo_goal, [23:17] zero
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [23:0]                         m_tdata,
    output logic                                m_tlast,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [serpgg_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [serpgg_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import serpgg_pkg::*;

    localparam int SINE_DEPTH = 1 << SINE_TABLE_BITS;
    localparam logic [SEG_W-1:0] SEG_LAST  = SEG_W'(SEGMENTS);
    localparam logic [SEG_W-1:0] SEG_FRONT = SEG_W'(SEGMENTS / 2);

    // configuration registers
    logic [15:0] pps_reg, ppt_reg, lead_reg;
    logic [8:0]  amp_ef_reg, amp_eb_reg, amp_of_reg, amp_ob_reg;
    logic [39:0] offset_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pps_reg    <= 16'd5215;
            ppt_reg    <= 16'd5215;
            lead_reg   <= 16'd8192;
            amp_ef_reg <= 9'd75;
            amp_eb_reg <= 9'd75;
            amp_of_reg <= 9'd150;
            amp_ob_reg <= 9'd150;
            offset_reg <= 40'd0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_PHASE_PER_SEGMENT: pps_reg    <= cfg_data[15:0];
                CFG_PHASE_PER_TIME:    ppt_reg    <= cfg_data[15:0];
                CFG_EVEN_LEAD:         lead_reg   <= cfg_data[15:0];
                CFG_AMP_EVEN_FRONT:    amp_ef_reg <= cfg_data[8:0];
                CFG_AMP_EVEN_BACK:     amp_eb_reg <= cfg_data[8:0];
                CFG_AMP_ODD_FRONT:     amp_of_reg <= cfg_data[8:0];
                CFG_AMP_ODD_BACK:      amp_ob_reg <= cfg_data[8:0];
                CFG_OFFSET_WORDS:      offset_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // constant sine table
    logic signed [15:0] sine_lut [SINE_DEPTH];
    for (genvar g = 0; g < SINE_DEPTH; g++) begin : g_lut
        assign sine_lut[g] = sine_entry(g, SINE_TABLE_BITS);
    end

    // pipeline advances whenever the output register can take a new goal
    logic en;
    assign en = !m_tvalid || m_tready;

    // sequencer
    logic             busy_reg;
    logic [SEG_W-1:0] cnt_reg;
    logic [15:0]      seg_acc_reg;
    logic [15:0]      time_phase_reg;
    logic             last_issue;
    logic             take;
    logic [31:0]      time_prod;

    assign last_issue = busy_reg && (cnt_reg == SEG_LAST);
    assign s_tready   = !busy_reg || (en && last_issue);
    assign take       = s_tvalid && s_tready;
    assign time_prod  = ppt_reg * s_tdata;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (take) begin
            busy_reg       <= 1'b1;
            cnt_reg        <= SEG_W'(1);
            seg_acc_reg    <= pps_reg;
            time_phase_reg <= time_prod[23:8];
        end else if (busy_reg && en) begin
            busy_reg    <= !last_issue;
            cnt_reg     <= cnt_reg + SEG_W'(1);
            seg_acc_reg <= seg_acc_reg + pps_reg;
        end
    end

    // stage 1: phase and per-segment coefficients
    logic             v1_reg;
    logic [SEG_W-1:0] n1_reg;
    logic [15:0]      phi1_reg;
    logic [8:0]       amp1_reg;
    logic [9:0]       off1_reg;
    logic             odd, front;

    assign odd   = cnt_reg[0];
    assign front = cnt_reg <= SEG_FRONT;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= busy_reg;
        end
        if (en) begin
            n1_reg   <= cnt_reg;
            phi1_reg <= seg_acc_reg + time_phase_reg + (odd ? 16'd0 : lead_reg);
            if (odd) begin
                amp1_reg <= front ? amp_of_reg : amp_ob_reg;
                off1_reg <= front ? offset_reg[29:20] : offset_reg[39:30];
            end else begin
                amp1_reg <= front ? amp_ef_reg : amp_eb_reg;
                off1_reg <= front ? offset_reg[9:0] : offset_reg[19:10];
            end
        end
    end

    // stage 2: sine lookup
    logic               v2_reg;
    logic [SEG_W-1:0]   n2_reg;
    logic signed [15:0] sine2_reg;
    logic [8:0]         amp2_reg;
    logic signed [9:0]  off2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (en) begin
            v2_reg <= v1_reg;
        end
        if (en) begin
            n2_reg    <= n1_reg;
            sine2_reg <= sine_lut[phi1_reg[15 -: SINE_TABLE_BITS]];
            amp2_reg  <= amp1_reg;
            off2_reg  <= off1_reg;
        end
    end

    // stage 3: offset*2^15 + amplitude*sine
    logic               v3_reg;
    logic [SEG_W-1:0]   n3_reg;
    logic signed [26:0] sum3_reg;
    logic signed [25:0] prod;
    logic signed [26:0] off_scaled;

    assign prod       = $signed({1'b0, amp2_reg}) * sine2_reg;
    assign off_scaled = {{2{off2_reg[9]}}, off2_reg, 15'd0};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (en) begin
            v3_reg <= v2_reg;
        end
        if (en) begin
            n3_reg   <= n2_reg;
            sum3_reg <= 27'(prod) + off_scaled;
        end
    end

    // stage 4: truncate toward zero, center, saturate
    logic signed [26:0] biased;
    logic signed [11:0] quot;
    logic signed [12:0] goal_full;
    logic [GOAL_W-1:0]  goal;
    logic               out_valid_reg;
    logic [SEG_W-1:0]   out_seg_reg;
    logic [GOAL_W-1:0]  out_goal_reg;
    logic               out_last_reg;

    assign biased    = sum3_reg + (sum3_reg[26] ? 27'sd32767 : 27'sd0);
    assign quot      = 12'(biased >>> 15);
    assign goal_full = 13'(quot) + GOAL_CENTER;

    always_comb begin
        if (goal_full < 0) begin
            goal = '0;
        end else if (goal_full > GOAL_MAX) begin
            goal = '1;
        end else begin
            goal = goal_full[GOAL_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (en) begin
            out_valid_reg <= v3_reg;
        end
        if (en) begin
            out_seg_reg  <= n3_reg;
            out_goal_reg <= goal;
            out_last_reg <= n3_reg == SEG_LAST;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_goal_reg, out_seg_reg};
    assign m_tlast  = out_last_reg;

endmodule

### sv/serpgg_checker.sv
// ----------------------------------------------------------------------------
// serpgg_checker
// Port-level checks for the serpenoid gait generator, bound to the top level.
// ----------------------------------------------------------------------------
module serpgg_checker #(
    parameter int SEGMENTS = 16
) (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic        m_tlast
);
    import serpgg_pkg::*;

    localparam logic [SEG_W-1:0] SEG_LAST = SEG_W'(SEGMENTS);

    // a held goal must not change under backpressure
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output item changed while stalled");

    a_last_seg: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tdata[6:0] == SEG_LAST)
        else $error("tlast on wrong segment");

    a_seg_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[6:0] != 7'd0 && m_tdata[6:0] <= SEG_LAST
                     && m_tdata[23:17] == 7'd0)
        else $error("segment out of range or pad bits set");

    // within a sweep the segments follow one by one
    a_next_seg: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && !m_tlast ##1 m_tvalid
            |-> m_tdata[6:0] == $past(m_tdata[6:0]) + 7'd1)
        else $error("segment sequence broken");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid right after reset");

endmodule

bind serpenoid_gait_generator_core serpgg_checker #(
    .SEGMENTS (SEGMENTS)
) u_serpgg_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
